// ===== rtl/core/max_heap_builder_assert.svh =====
// Assertion macros shared by the max-heap builder modules.
`ifndef MAX_HEAP_BUILDER_ASSERT_SVH
`define MAX_HEAP_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mhb_pkg.sv =====
// Package with the shared constants and controller-datapath interface types.
`default_nettype none

package mhb_pkg;

    localparam int DEF_STORE_DEPTH = 32;
    localparam int DEF_VALUE_BITS  = 32;
    localparam int OUT_VALUE_BITS  = 32;
    localparam int POS_BITS        = 5;

    typedef struct packed {
        logic accept;
        logic init_k;
        logic start_node;
        logic latch_held;
        logic read_kids;
        logic sift_step;
        logic emit_first;
        logic emit_load;
        logic emit_next;
        logic clear_run;
    } mhb_cmd_t;

    typedef struct packed {
        logic count_ge2;
        logic count_zero;
        logic k_zero;
        logic sift_move;
        logic last_pos;
        logic out_valid;
        logic out_taken;
    } mhb_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mhb_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module mhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/mhb_datapath.sv =====
// Datapath: element store, fill count, sift-down compare unit and output register.
`default_nettype none
`include "max_heap_builder_assert.svh"

module mhb_datapath
    import mhb_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mhb_cmd_t                    cmd,
    output mhb_status_t                      status,
    input  wire logic signed [31:0]          sample_value,
    input  wire logic                        heap_stall,
    output logic                             heap_valid,
    output logic signed [OUT_VALUE_BITS-1:0] heap_value,
    output logic [POS_BITS-1:0]              heap_position,
    output logic                             run_end,
    output logic                             dropped_any
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 2;

    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] node_reg, node_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [VALUE_BITS-1:0]     held_reg;
    logic signed [OUT_VALUE_BITS-1:0] value_reg;
    logic [POS_BITS-1:0]              position_reg;
    logic                             run_end_reg;
    logic                             dropped_reg;

    logic                         we;
    logic [ADDR_W-1:0]            waddr;
    logic [VALUE_BITS-1:0]        wdata;
    logic [ADDR_W-1:0]            raddr_a, raddr_b;
    logic [VALUE_BITS-1:0]        rdata_a, rdata_b;
    logic signed [VALUE_BITS-1:0] left_val, right_val, best_val;

    logic              full;
    logic [IDX_W-1:0]  left_idx, right_idx;
    logic              left_ok, right_ok;
    logic              take_left, take_right, move;
    logic [ADDR_W-1:0] k_dec;
    logic              last_pos;

    mhb_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        full       = (fill_reg == CNT_W'(STORE_DEPTH));
        left_idx   = IDX_W'({node_reg, 1'b1});
        right_idx  = left_idx + IDX_W'(1);
        left_ok    = left_idx < IDX_W'(fill_reg);
        right_ok   = right_idx < IDX_W'(fill_reg);
        left_val   = $signed(rdata_a);
        right_val  = $signed(rdata_b);
        take_left  = left_ok && (left_val > held_reg);
        best_val   = take_left ? left_val : held_reg;
        take_right = right_ok && (right_val > best_val);
        move       = take_left || take_right;
        k_dec      = k_reg - ADDR_W'(1);
        last_pos   = (CNT_W'(pos_reg) + CNT_W'(1)) == fill_reg;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = node_reg;
        wdata = held_reg;
        if (cmd.accept && !full)
        begin
            we    = 1'b1;
            waddr = fill_reg[ADDR_W-1:0];
            wdata = VALUE_BITS'(sample_value);
        end
        else if (cmd.sift_step)
        begin
            we    = 1'b1;
            waddr = node_reg;
            if (take_right)
            begin
                wdata = right_val;
            end
            else if (take_left)
            begin
                wdata = left_val;
            end
            else
            begin
                wdata = held_reg;
            end
        end
    end

    always_comb
    begin
        raddr_b = right_idx[ADDR_W-1:0];
        if (cmd.start_node)
        begin
            raddr_a = k_dec;
        end
        else if (cmd.read_kids)
        begin
            raddr_a = left_idx[ADDR_W-1:0];
        end
        else if (cmd.emit_first)
        begin
            raddr_a = '0;
        end
        else if (cmd.emit_next)
        begin
            raddr_a = pos_reg + ADDR_W'(1);
        end
        else
        begin
            raddr_a = pos_reg;
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        node_next      = node_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (cmd.accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
        if (cmd.init_k)
        begin
            k_next = ADDR_W'(fill_reg >> 1);
        end
        if (cmd.start_node)
        begin
            k_next    = k_dec;
            node_next = k_dec;
        end
        if (cmd.sift_step && move)
        begin
            node_next = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
        end
        if (cmd.emit_first)
        begin
            pos_next = '0;
        end
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        if (cmd.emit_next)
        begin
            pos_next       = pos_reg + ADDR_W'(1);
            out_valid_next = 1'b0;
        end
        if (cmd.clear_run)
        begin
            fill_next      = '0;
            ovf_next       = 1'b0;
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            node_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            node_reg      <= node_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_held)
        begin
            held_reg <= $signed(rdata_a);
        end
        if (cmd.emit_load)
        begin
            value_reg    <= OUT_VALUE_BITS'($signed(rdata_a));
            position_reg <= POS_BITS'(pos_reg);
            run_end_reg  <= last_pos;
            dropped_reg  <= ovf_reg;
        end
    end

    always_comb
    begin
        status.count_ge2  = fill_reg >= CNT_W'(2);
        status.count_zero = (fill_reg == '0);
        status.k_zero     = (k_reg == '0);
        status.sift_move  = move;
        status.last_pos   = last_pos;
        status.out_valid  = out_valid_reg;
        status.out_taken  = out_valid_reg && !heap_stall;
    end

    assign heap_valid    = out_valid_reg;
    assign heap_value    = value_reg;
    assign heap_position = position_reg;
    assign run_end       = run_end_reg;
    assign dropped_any   = dropped_reg;

    `MHB_ASSERT_NOW(a_fill_in_range, 1'b1, fill_reg <= CNT_W'(STORE_DEPTH),
        "Fill count exceeds the store depth.")
    `MHB_ASSERT_NOW(a_emit_in_range, out_valid_reg, CNT_W'(pos_reg) < fill_reg,
        "Emitted position lies beyond the stored elements.")
    `MHB_ASSERT_NOW(a_sift_in_range, cmd.sift_step, CNT_W'(node_reg) < fill_reg,
        "Sift-down writes beyond the stored elements.")

endmodule

`default_nettype wire

// ===== rtl/core/mhb_ctrl.sv =====
// Controller state machine sequencing load, heap build and emission.
`default_nettype none
`include "max_heap_builder_assert.svh"

module mhb_ctrl
    import mhb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sample_valid,
    input  wire logic        final_item,
    output logic             sample_stall,
    output mhb_cmd_t         cmd,
    input  wire mhb_status_t status
);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_CLOSE     = 3'd1;
    localparam logic [2:0] S_NEXT_K    = 3'd2;
    localparam logic [2:0] S_RD_NODE   = 3'd3;
    localparam logic [2:0] S_RD_KIDS   = 3'd4;
    localparam logic [2:0] S_SIFT      = 3'd5;
    localparam logic [2:0] S_EMIT_LOAD = 3'd6;
    localparam logic [2:0] S_EMIT_WAIT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign sample_stall = (state_reg != S_LOAD);
    assign accept       = sample_valid && !sample_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    if (final_item)
                    begin
                        state_next = S_CLOSE;
                    end
                end
            end
            S_CLOSE:
            begin
                if (status.count_ge2)
                begin
                    cmd.init_k = 1'b1;
                    state_next = S_NEXT_K;
                end
                else if (status.count_zero)
                begin
                    cmd.clear_run = 1'b1;
                    state_next    = S_LOAD;
                end
                else
                begin
                    cmd.emit_first = 1'b1;
                    state_next     = S_EMIT_LOAD;
                end
            end
            S_NEXT_K:
            begin
                if (status.k_zero)
                begin
                    cmd.emit_first = 1'b1;
                    state_next     = S_EMIT_LOAD;
                end
                else
                begin
                    cmd.start_node = 1'b1;
                    state_next     = S_RD_NODE;
                end
            end
            S_RD_NODE:
            begin
                cmd.latch_held = 1'b1;
                cmd.read_kids  = 1'b1;
                state_next     = S_SIFT;
            end
            S_RD_KIDS:
            begin
                cmd.read_kids = 1'b1;
                state_next    = S_SIFT;
            end
            S_SIFT:
            begin
                cmd.sift_step = 1'b1;
                state_next    = status.sift_move ? S_RD_KIDS : S_NEXT_K;
            end
            S_EMIT_LOAD:
            begin
                cmd.emit_load = 1'b1;
                state_next    = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (status.out_taken)
                begin
                    if (status.last_pos)
                    begin
                        cmd.clear_run = 1'b1;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_EMIT_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MHB_ASSERT_NEXT(a_final_closes, accept && final_item, state_reg == S_CLOSE,
        "A final request did not close the run.")
    `MHB_ASSERT_NOW(a_wait_has_result, state_reg == S_EMIT_WAIT, status.out_valid,
        "Waiting for the output side without a result held.")
    `MHB_ASSERT_NOW(a_single_action, 1'b1,
        $onehot0({cmd.accept, cmd.init_k, cmd.start_node, cmd.sift_step,
                  cmd.emit_first, cmd.emit_load, cmd.emit_next}),
        "More than one datapath action issued in a cycle.")

endmodule

`default_nettype wire

// ===== rtl/core/max_heap_builder.sv =====
// Top level of the max-heap builder: controller and datapath.
//
//   Channel   Valid          Stall          Payload
//   input     sample_valid   sample_stall   sample_value, final_item
//   output    heap_valid     heap_stall     heap_value, heap_position, run_end, dropped_any
//
// Loading takes one request per cycle; the final request closes the run.
// The build runs S_NEXT_K, S_RD_NODE and S_SIFT per parent node and S_RD_KIDS and S_SIFT
// per level moved down, set by the registered store reads. Results go out one at a time.
// Reset clears the fill count, overflow flag and control; store contents stay undefined.
// Input is stalled from the final request until the last result is taken; a stalled
// result holds in the output register.
`default_nettype none

module max_heap_builder
    import mhb_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        sample_valid,
    output logic                             sample_stall,
    input  wire logic signed [31:0]          sample_value,
    input  wire logic                        final_item,
    output logic                             heap_valid,
    input  wire logic                        heap_stall,
    output logic signed [OUT_VALUE_BITS-1:0] heap_value,
    output logic [POS_BITS-1:0]              heap_position,
    output logic                             run_end,
    output logic                             dropped_any
);

    mhb_cmd_t    cmd;
    mhb_status_t status;

    mhb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .final_item   (final_item),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .status       (status)
    );

    mhb_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_value  (sample_value),
        .heap_stall    (heap_stall),
        .heap_valid    (heap_valid),
        .heap_value    (heap_value),
        .heap_position (heap_position),
        .run_end       (run_end),
        .dropped_any   (dropped_any)
    );

endmodule

`default_nettype wire
